/* sv/rccf_pkg.sv */
// ----------------------------------------------------------------------------
// rccf_pkg
// shared types, constants and helpers of the region clamped camera follow
// ----------------------------------------------------------------------------
package rccf_pkg;

    // table depth default
    localparam int MAX_REGIONS_DEF = 16;

    // field widths
    localparam int COORD_W = 24;
    localparam int EXT_W   = 23;
    localparam int DT_W    = 16;
    localparam int FACT_W  = DT_W + 3;
    localparam int ST_W    = 3;
    localparam int WORD_W  = 30;

    // configuration port
    localparam int CFG_DW = 32;
    localparam int CFG_AW = 3;
    localparam logic REG_VIEW_W = 1'b0;
    localparam logic REG_VIEW_H = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_FOLLOW = 3'd0;
    localparam logic [ST_W-1:0] ST_SNAP   = 3'd1;
    localparam logic [ST_W-1:0] ST_NONE   = 3'd2;
    localparam logic [ST_W-1:0] ST_ADDED  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd4;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word COORD_MIN = -t_word'(2 ** (COORD_W - 1));
    localparam t_word COORD_MAX = t_word'(2 ** (COORD_W - 1)) - t_word'(1);

    // stored rectangle
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [EXT_W-1:0]          width;
        logic [EXT_W-1:0]          height;
    } t_rect;

    // shared unit operations
    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_HI,
        ALU_HOLD,
        ALU_CLAMP
    } t_alu_op;

    // two lanes (x and y), three operands each
    typedef struct packed {
        t_alu_op op;
        t_word   ax;
        t_word   bx;
        t_word   cx;
        t_word   ay;
        t_word   by;
        t_word   cy;
    } t_alu_req;

    typedef struct packed {
        t_word rx;
        t_word ry;
        logic  hit;
    } t_alu_rsp;

    // sign extend a coordinate to the working width
    function automatic t_word sx_coord(input logic [COORD_W-1:0] v);
        sx_coord = {{(WORD_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // zero extend an extent to the working width
    function automatic t_word ux_ext(input logic [EXT_W-1:0] v);
        ux_ext = {{(WORD_W-EXT_W){1'b0}}, v};
    endfunction

endpackage

/* sv/rccf_if.sv */
// ----------------------------------------------------------------------------
// rccf_if
// input and result channels of the region clamped camera follow
// ----------------------------------------------------------------------------
interface rccf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  opcode;
    logic signed [rccf_pkg::COORD_W-1:0]   target_x;
    logic signed [rccf_pkg::COORD_W-1:0]   target_y;
    logic [rccf_pkg::DT_W-1:0]             time_step;
    logic signed [rccf_pkg::COORD_W-1:0]   region_left;
    logic signed [rccf_pkg::COORD_W-1:0]   region_top;
    logic [rccf_pkg::EXT_W-1:0]            region_width;
    logic [rccf_pkg::EXT_W-1:0]            region_height;

    modport source (
        output valid, opcode, target_x, target_y, time_step,
               region_left, region_top, region_width, region_height,
        input  ready
    );
    modport sink (
        input  valid, opcode, target_x, target_y, time_step,
               region_left, region_top, region_width, region_height,
        output ready
    );
endinterface

interface rccf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rccf_pkg::COORD_W-1:0]   center_x;
    logic signed [rccf_pkg::COORD_W-1:0]   center_y;
    logic [rccf_pkg::ST_W-1:0]             status;

    modport source (output valid, center_x, center_y, status, input ready);
    modport sink   (input valid, center_x, center_y, status, output ready);
endinterface

/* sv/rccf_cfg.sv */
// ----------------------------------------------------------------------------
// rccf_cfg
// apb register file holding the viewport size
// ----------------------------------------------------------------------------
module rccf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rccf_pkg::CFG_AW-1:0]   paddr,
    input  logic [rccf_pkg::CFG_DW-1:0]   pwdata,
    output logic [rccf_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output logic [rccf_pkg::EXT_W-1:0]    o_view_w,
    output logic [rccf_pkg::EXT_W-1:0]    o_view_h
);

    logic [rccf_pkg::EXT_W-1:0] r_view_w;
    logic [rccf_pkg::EXT_W-1:0] r_view_h;
    logic                       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_w <= rccf_pkg::EXT_W'(81920);
            r_view_h <= rccf_pkg::EXT_W'(46080);
        end else if (w_wr) begin
            unique case (paddr[2])
                rccf_pkg::REG_VIEW_W: r_view_w <= pwdata[rccf_pkg::EXT_W-1:0];
                rccf_pkg::REG_VIEW_H: r_view_h <= pwdata[rccf_pkg::EXT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            rccf_pkg::REG_VIEW_W:
                prdata = {{(rccf_pkg::CFG_DW-rccf_pkg::EXT_W){1'b0}}, r_view_w};
            rccf_pkg::REG_VIEW_H:
                prdata = {{(rccf_pkg::CFG_DW-rccf_pkg::EXT_W){1'b0}}, r_view_h};
            default: prdata = '0;
        endcase
    end

    assign o_view_w = r_view_w;
    assign o_view_h = r_view_h;

endmodule

/* sv/rccf_table.sv */
// ----------------------------------------------------------------------------
// rccf_table
// region table memory, one write and one registered read port
// ----------------------------------------------------------------------------
module rccf_table #(
    parameter int DEPTH = rccf_pkg::MAX_REGIONS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  rccf_pkg::t_rect i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output rccf_pkg::t_rect o_rdata
);

    rccf_pkg::t_rect r_mem [DEPTH];
    rccf_pkg::t_rect r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rccf_alu.sv */
// ----------------------------------------------------------------------------
// rccf_alu
// shared two-lane arithmetic unit: add, subtract, multiply, bounds, containment, clamp
// ----------------------------------------------------------------------------
module rccf_alu (
    input  rccf_pkg::t_alu_req i_req,
    output rccf_pkg::t_alu_rsp o_rsp
);

    localparam int PROD_W = 2 * rccf_pkg::WORD_W;
    localparam int SH     = 16;

    // one lane of the unit
    function automatic rccf_pkg::t_word lane(input rccf_pkg::t_alu_op op,
                                             input rccf_pkg::t_word a,
                                             input rccf_pkg::t_word b,
                                             input rccf_pkg::t_word c);
        logic signed [PROD_W-1:0] prod;
        rccf_pkg::t_word          v;
        prod = '0;
        v    = '0;
        unique case (op)
            rccf_pkg::ALU_ADD: v = a + b;
            rccf_pkg::ALU_SUB: v = a - b;
            rccf_pkg::ALU_MUL: begin
                // arithmetic shift floors toward minus infinity
                prod = a * b;
                v    = prod[SH+rccf_pkg::WORD_W-1:SH];
            end
            rccf_pkg::ALU_HI: v = a + b - c;
            rccf_pkg::ALU_HOLD: begin
                v = rccf_pkg::t_word'((a >= b) && (a < b + c));
            end
            rccf_pkg::ALU_CLAMP: begin
                v = a;
                if (v < b) v = b;
                if (v > c) v = c;
                if (v < rccf_pkg::COORD_MIN) v = rccf_pkg::COORD_MIN;
                if (v > rccf_pkg::COORD_MAX) v = rccf_pkg::COORD_MAX;
            end
            default: v = '0;
        endcase
        lane = v;
    endfunction

    rccf_pkg::t_word w_rx;
    rccf_pkg::t_word w_ry;

    assign w_rx = lane(i_req.op, i_req.ax, i_req.bx, i_req.cx);
    assign w_ry = lane(i_req.op, i_req.ay, i_req.by, i_req.cy);

    assign o_rsp.rx  = w_rx;
    assign o_rsp.ry  = w_ry;
    assign o_rsp.hit = w_rx[0] && w_ry[0];

endmodule

/* sv/region_clamped_camera_follow.sv */
// ----------------------------------------------------------------------------
// region_clamped_camera_follow
// camera center that follows a target inside a table of clamping regions
// ----------------------------------------------------------------------------
// One word at a time. An add goes to output; a follow update runs containment,
// subtract, multiply, step, low and high bound, clamp; a snap runs the test, the
// scan to the matching slot, bounds and clamp; with no region, the scan (or just
// the test, if the table is empty) leads to output. The sequencer drives one
// shared two-lane arithmetic unit once per cycle and scans the region table one
// slot per cycle through its registered read port. Results sit in an output
// register; a new word is taken while the last one waits. The user must write
// the viewport size over the apb port while the block is idle; not enforced.
module region_clamped_camera_follow #(
    parameter int MAX_REGIONS = rccf_pkg::MAX_REGIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rccf_in_if.sink                       i_item,
    rccf_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rccf_pkg::CFG_AW-1:0]   paddr,
    input  logic [rccf_pkg::CFG_DW-1:0]   pwdata,
    output logic [rccf_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_HOLD_ACT,
        S_SUB,
        S_MUL,
        S_STEP,
        S_SCAN,
        S_LO,
        S_HI,
        S_CLAMP,
        S_OUT
    } t_state;

    t_state                             r_state;
    logic [CNT_W-1:0]                   r_count;
    logic [IDX_W-1:0]                   r_idx;
    rccf_pkg::t_rect                    r_act;
    logic signed [rccf_pkg::COORD_W-1:0] r_cx;
    logic signed [rccf_pkg::COORD_W-1:0] r_cy;
    logic signed [rccf_pkg::COORD_W-1:0] r_tx;
    logic signed [rccf_pkg::COORD_W-1:0] r_ty;
    logic [rccf_pkg::FACT_W-1:0]        r_factor;
    rccf_pkg::t_word                    r_vx;
    rccf_pkg::t_word                    r_vy;
    rccf_pkg::t_word                    r_lox;
    rccf_pkg::t_word                    r_loy;
    rccf_pkg::t_word                    r_hix;
    rccf_pkg::t_word                    r_hiy;
    logic [rccf_pkg::ST_W-1:0]          r_status;
    logic                               r_ovalid;
    logic signed [rccf_pkg::COORD_W-1:0] r_ox;
    logic signed [rccf_pkg::COORD_W-1:0] r_oy;
    logic [rccf_pkg::ST_W-1:0]          r_ost;

    logic [rccf_pkg::EXT_W-1:0] w_view_w;
    logic [rccf_pkg::EXT_W-1:0] w_view_h;
    rccf_pkg::t_word            w_half_w;
    rccf_pkg::t_word            w_half_h;
    logic                       w_accept;
    logic                       w_room;
    logic                       w_we;
    rccf_pkg::t_rect            w_wdata;
    logic [IDX_W-1:0]           w_raddr;
    rccf_pkg::t_rect            w_rdata;
    rccf_pkg::t_alu_req         w_req;
    rccf_pkg::t_alu_rsp         w_rsp;
    logic                       w_last;
    logic                       w_load;

    // viewport registers
    rccf_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_view_w (w_view_w),
        .o_view_h (w_view_h)
    );

    assign w_half_w = rccf_pkg::ux_ext({1'b0, w_view_w[rccf_pkg::EXT_W-1:1]});
    assign w_half_h = rccf_pkg::ux_ext({1'b0, w_view_h[rccf_pkg::EXT_W-1:1]});

    // input handshake and table write
    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_room       = (r_count < CNT_MAX);
    assign w_we         = w_accept && !i_item.opcode && w_room;
    assign w_wdata      = '{left:   i_item.region_left,
                            top:    i_item.region_top,
                            width:  i_item.region_width,
                            height: i_item.region_height};

    // scan address runs one slot ahead of the compare
    assign w_raddr = (r_state == S_SCAN) ? IDX_W'(r_idx + IDX_W'(1)) : '0;
    assign w_last  = (CNT_W'(r_idx) + CNT_W'(1)) >= r_count;

    rccf_table #(
        .DEPTH (MAX_REGIONS),
        .AW    (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // operand selection for the shared unit
    always_comb begin
        w_req    = '0;
        w_req.op = rccf_pkg::ALU_ADD;
        unique case (r_state)
            S_HOLD_ACT: begin
                w_req.op = rccf_pkg::ALU_HOLD;
                w_req.ax = rccf_pkg::sx_coord(r_tx);
                w_req.bx = rccf_pkg::sx_coord(r_act.left);
                w_req.cx = rccf_pkg::ux_ext(r_act.width);
                w_req.ay = rccf_pkg::sx_coord(r_ty);
                w_req.by = rccf_pkg::sx_coord(r_act.top);
                w_req.cy = rccf_pkg::ux_ext(r_act.height);
            end
            S_SUB: begin
                w_req.op = rccf_pkg::ALU_SUB;
                w_req.ax = rccf_pkg::sx_coord(r_tx);
                w_req.bx = rccf_pkg::sx_coord(r_cx);
                w_req.ay = rccf_pkg::sx_coord(r_ty);
                w_req.by = rccf_pkg::sx_coord(r_cy);
            end
            S_MUL: begin
                w_req.op = rccf_pkg::ALU_MUL;
                w_req.ax = r_vx;
                w_req.bx = {{(rccf_pkg::WORD_W-rccf_pkg::FACT_W){1'b0}}, r_factor};
                w_req.ay = r_vy;
                w_req.by = {{(rccf_pkg::WORD_W-rccf_pkg::FACT_W){1'b0}}, r_factor};
            end
            S_STEP: begin
                w_req.op = rccf_pkg::ALU_ADD;
                w_req.ax = rccf_pkg::sx_coord(r_cx);
                w_req.bx = r_vx;
                w_req.ay = rccf_pkg::sx_coord(r_cy);
                w_req.by = r_vy;
            end
            S_SCAN: begin
                w_req.op = rccf_pkg::ALU_HOLD;
                w_req.ax = rccf_pkg::sx_coord(r_tx);
                w_req.bx = rccf_pkg::sx_coord(w_rdata.left);
                w_req.cx = rccf_pkg::ux_ext(w_rdata.width);
                w_req.ay = rccf_pkg::sx_coord(r_ty);
                w_req.by = rccf_pkg::sx_coord(w_rdata.top);
                w_req.cy = rccf_pkg::ux_ext(w_rdata.height);
            end
            S_LO: begin
                w_req.op = rccf_pkg::ALU_ADD;
                w_req.ax = rccf_pkg::sx_coord(r_act.left);
                w_req.bx = w_half_w;
                w_req.ay = rccf_pkg::sx_coord(r_act.top);
                w_req.by = w_half_h;
            end
            S_HI: begin
                w_req.op = rccf_pkg::ALU_HI;
                w_req.ax = rccf_pkg::sx_coord(r_act.left);
                w_req.bx = rccf_pkg::ux_ext(r_act.width);
                w_req.cx = w_half_w;
                w_req.ay = rccf_pkg::sx_coord(r_act.top);
                w_req.by = rccf_pkg::ux_ext(r_act.height);
                w_req.cy = w_half_h;
            end
            S_CLAMP: begin
                w_req.op = rccf_pkg::ALU_CLAMP;
                w_req.ax = r_vx;
                w_req.bx = r_lox;
                w_req.cx = r_hix;
                w_req.ay = r_vy;
                w_req.by = r_loy;
                w_req.cy = r_hiy;
            end
            default: ;
        endcase
    end

    rccf_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_load = (r_state == S_OUT) && (!r_ovalid || o_result.ready);

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_act    <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_status <= rccf_pkg::ST_NONE;
            r_ovalid <= 1'b0;
        end else begin
            // result valid held until taken, raised on load
            r_ovalid <= w_load || (r_ovalid && !o_result.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!i_item.opcode) begin
                            if (w_room) begin
                                r_count  <= r_count + CNT_W'(1);
                                r_status <= rccf_pkg::ST_ADDED;
                            end else begin
                                r_status <= rccf_pkg::ST_FULL;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_tx     <= i_item.target_x;
                            r_ty     <= i_item.target_y;
                            r_factor <= {i_item.time_step, 2'b00}
                                        + rccf_pkg::FACT_W'(i_item.time_step);
                            r_state  <= S_HOLD_ACT;
                        end
                    end
                end
                S_HOLD_ACT: begin
                    if (w_rsp.hit) begin
                        r_state <= S_SUB;
                    end else if (r_count == '0) begin
                        r_status <= rccf_pkg::ST_NONE;
                        r_state  <= S_OUT;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SUB: begin
                    r_vx    <= w_rsp.rx;
                    r_vy    <= w_rsp.ry;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_vx    <= w_rsp.rx;
                    r_vy    <= w_rsp.ry;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_vx     <= w_rsp.rx;
                    r_vy     <= w_rsp.ry;
                    r_status <= rccf_pkg::ST_FOLLOW;
                    r_state  <= S_LO;
                end
                S_SCAN: begin
                    if (w_rsp.hit) begin
                        r_act    <= w_rdata;
                        r_vx     <= rccf_pkg::sx_coord(r_tx);
                        r_vy     <= rccf_pkg::sx_coord(r_ty);
                        r_status <= rccf_pkg::ST_SNAP;
                        r_state  <= S_LO;
                    end else if (w_last) begin
                        r_status <= rccf_pkg::ST_NONE;
                        r_state  <= S_OUT;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_LO: begin
                    r_lox   <= w_rsp.rx;
                    r_loy   <= w_rsp.ry;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_hix   <= w_rsp.rx;
                    r_hiy   <= w_rsp.ry;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_cx    <= w_rsp.rx[rccf_pkg::COORD_W-1:0];
                    r_cy    <= w_rsp.ry[rccf_pkg::COORD_W-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_ox     <= r_cx;
                        r_oy     <= r_cy;
                        r_ost    <= r_status;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid    = r_ovalid;
    assign o_result.center_x = r_ox;
    assign o_result.center_y = r_oy;
    assign o_result.status   = r_ost;

    // an accepted word always starts work
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE)
    ) else $error("block still idle after accepting a word");

    // the scan never compares a slot beyond the fill count
    a_scan_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_idx) < r_count)
    ) else $error("region scan past the filled slots");

    // a dropped add leaves the table count alone
    a_full_holds_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_item.opcode && !w_room) |=> $stable(r_count)
    ) else $error("table count changed on a dropped add");

    // loading the result register raises valid
    a_load_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_result.valid && (r_state == S_IDLE))
    ) else $error("result not presented after load");

endmodule
